### rtl/auto_range_frequency_meter_macros.svh
// Assertion shorthands for the checker file.
`ifndef AUTO_RANGE_FREQUENCY_METER_MACROS_SVH
`define AUTO_RANGE_FREQUENCY_METER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, quiet during reset.
`define AFM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frequency meter check failed");

// Next-cycle implication, sampled on clk_i, quiet during reset.
`define AFM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frequency meter check failed");

`endif

### rtl/afm_pkg.sv
package afm_pkg;

  // Field and arithmetic widths
  localparam int unsigned READ_W     = 56;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned NUM_W      = 36;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_METER_ENABLE   = 2'd0;
  localparam logic [1:0] REG_GATE_TIME_SEL  = 2'd1;
  localparam logic [1:0] REG_REF_CLOCK_SEL  = 2'd2;
  localparam logic [1:0] REG_PERIOD_CNT_SEL = 2'd3;

  // Gate scale codes; any other code acts as divide by ten
  localparam logic [1:0] GATE_X10 = 2'd0;
  localparam logic [1:0] GATE_X1  = 2'd1;

  // Period averaging code for 100 periods; the spare code acts the same
  localparam logic [1:0] PER_X100 = 2'd2;

  // Numerator used when the meter is disabled
  localparam logic [NUM_W-1:0] NUM_FIXED = 36'd1000000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_RUN,
    ST_SCALE,
    ST_CMP,
    ST_PUSH
  } afm_state_e;

  // Reference clock times periods averaged: 1e5 * 10^(ref_sel + min(per_sel, 2))
  function automatic logic [NUM_W-1:0] period_num(input logic [1:0] ref_sel,
                                                  input logic [1:0] per_sel);
    logic [1:0] ps;
    logic [2:0] e;
    logic [NUM_W-1:0] v;
    ps = (per_sel > PER_X100) ? PER_X100 : per_sel;
    e  = {1'b0, ref_sel} + {1'b0, ps};
    unique case (e)
      3'd0:    v = 36'd100000;
      3'd1:    v = 36'd1000000;
      3'd2:    v = 36'd10000000;
      3'd3:    v = 36'd100000000;
      3'd4:    v = 36'd1000000000;
      3'd5:    v = 36'd10000000000;
      default: v = 36'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/afm_div.sv
module afm_div #(
  parameter int unsigned DW    = 52,
  parameter int unsigned DEN_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DW-1:0]    dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DW-1:0]    quot_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [DEN_W-1:0] rem_q;
  logic [DW-1:0]    quo_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DEN_W:0]   trial;
  logic             fits;
  logic [DEN_W:0]   diff;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, quo_q[DW-1]};
    fits  = (trial >= {1'b0, divisor_i});
    diff  = trial - {1'b0, divisor_i};
  end

  // Control: count the steps, pulse done after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out at the top while quotient bits enter below
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_q <= {quo_q[DW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

### rtl/afm_window.sv
module afm_window (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [afm_pkg::READ_W-1:0]  reading_i,
  input  logic [afm_pkg::READ_W-1:0]  prev_i,
  output logic                        in_window_o
);

  localparam int unsigned PW = afm_pkg::READ_W + 4;

  logic [PW-1:0] r10_q;
  logic [PW-1:0] p9_q;
  logic [PW-1:0] p11_q;

  // Scale reading by 10 and previous by 9 and 11 with shift-adds
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r10_q <= {1'b0, reading_i, 3'b000} + {3'b000, reading_i, 1'b0};
      p9_q  <= {1'b0, prev_i, 3'b000} + {4'b0000, prev_i};
      p11_q <= {1'b0, prev_i, 3'b000} + {3'b000, prev_i, 1'b0} + {4'b0000, prev_i};
    end
  end

  // Reading lies within 0.9 to 1.1 of the previous one
  assign in_window_o = !((r10_q < p9_q) || (r10_q > p11_q));

endmodule

### rtl/auto_range_frequency_meter.sv
// When a reading is computed, an input transfer passes through the divider start, divider
// run, scale, compare and push states, with the shared divider giving one quotient bit per
// cycle; a zero period count skips the divider states, and an item with no reading goes to push.
// Throughput: one item at a time; the next input transfer is taken once the result
// is handed to the output register. Reset is asynchronous, active low, and clears
// mode, readings, configuration and output valid.
module auto_range_frequency_meter #(
  parameter int unsigned LOW_COUNT_LIMIT = 1000,
  parameter int unsigned FRAC_BITS       = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream
  input  logic                              s_tvalid_i,
  output logic                              s_tready_o,
  input  logic [63:0]                       s_tdata_i,  // gate_count, period_count
  input  logic [1:0]                        s_tuser_i,  // gate_ready, period_ready
  // Result stream
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  output logic [55:0]                       m_tdata_o,  // frequency
  output logic [1:0]                        m_tuser_o,  // unstable, period_mode
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [afm_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [afm_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [afm_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int unsigned READ_W = afm_pkg::READ_W;
  localparam int unsigned NUM_W  = afm_pkg::NUM_W;
  localparam int unsigned CNT_W  = afm_pkg::CNT_W;
  localparam int unsigned DW     = NUM_W + FRAC_BITS;
  localparam int unsigned QX_W   = (DW > READ_W) ? DW : READ_W + 1;

  // Configuration registers
  logic       meter_enable_q;
  logic [1:0] gate_time_sel_q;
  logic [1:0] ref_clock_sel_q;
  logic [1:0] period_cnt_sel_q;
  logic       cfg_wr;

  // Sequencer and state
  afm_pkg::afm_state_e state_q, state_d;
  logic                mode_q;
  logic [READ_W-1:0]   prev_q;
  logic [READ_W-1:0]   held_q;
  logic                unst_q;
  logic [NUM_W-1:0]    num_q;
  logic [CNT_W-1:0]    den_q;
  logic [READ_W-1:0]   r_q;

  // Output register
  logic                m_tvalid_q;
  logic [READ_W-1:0]   m_tdata_q;
  logic [1:0]          m_tuser_q;

  // Input fields
  logic                gate_ready;
  logic                period_ready;
  logic [CNT_W-1:0]    gate_count;
  logic [CNT_W-1:0]    period_count;

  // Item decode
  logic                accept;
  logic                gate_take;
  logic                gate_low;
  logic                mode_after_gate;
  logic                per_take;
  logic                gate_reading;
  logic                per_divide;
  logic                per_zero;
  logic [1:0]          gate_sel;
  logic [NUM_W-1:0]    gate_num;
  logic [CNT_W-1:0]    gate_den;

  // Sequencer outputs
  logic                div_start;
  logic                win_en;
  logic                out_free;

  // Shared units
  logic [DW-1:0]       dividend;
  logic                div_done;
  logic [DW-1:0]       div_quot;
  logic [QX_W-1:0]     quot_ext;
  logic [READ_W-1:0]   quot_sat;
  logic                in_window;

  assign gate_ready   = s_tuser_i[0];
  assign period_ready = s_tuser_i[1];
  assign gate_count   = s_tdata_i[31:0];
  assign period_count = s_tdata_i[63:32];

  // Configuration write and read
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meter_enable_q   <= 1'b0;
      gate_time_sel_q  <= 2'd0;
      ref_clock_sel_q  <= 2'd0;
      period_cnt_sel_q <= 2'd0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        afm_pkg::REG_METER_ENABLE:   meter_enable_q   <= pwdata[0];
        afm_pkg::REG_GATE_TIME_SEL:  gate_time_sel_q  <= pwdata[1:0];
        afm_pkg::REG_REF_CLOCK_SEL:  ref_clock_sel_q  <= pwdata[1:0];
        afm_pkg::REG_PERIOD_CNT_SEL: period_cnt_sel_q <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      afm_pkg::REG_METER_ENABLE:   prdata = {31'd0, meter_enable_q};
      afm_pkg::REG_GATE_TIME_SEL:  prdata = {30'd0, gate_time_sel_q};
      afm_pkg::REG_REF_CLOCK_SEL:  prdata = {30'd0, ref_clock_sel_q};
      afm_pkg::REG_PERIOD_CNT_SEL: prdata = {30'd0, period_cnt_sel_q};
      default:                     prdata = '0;
    endcase
  end

  // Decode what the item does: gate path first, then period path
  always_comb begin
    accept          = s_tvalid_i && s_tready_o;
    gate_take       = gate_ready && !mode_q;
    gate_low        = gate_count < CNT_W'(LOW_COUNT_LIMIT);
    mode_after_gate = mode_q || (gate_take && gate_low);
    per_take        = period_ready && mode_after_gate;
    gate_reading    = gate_take && !gate_low;
    per_divide      = per_take && (period_count != '0);
    per_zero        = per_take && (period_count == '0);
    gate_sel        = meter_enable_q ? gate_time_sel_q : afm_pkg::GATE_X10;
    priority case (gate_sel)
      afm_pkg::GATE_X10: begin
        gate_num = {1'b0, gate_count, 3'b000} + {3'b000, gate_count, 1'b0};
        gate_den = CNT_W'(1);
      end
      afm_pkg::GATE_X1: begin
        gate_num = NUM_W'(gate_count);
        gate_den = CNT_W'(1);
      end
      default: begin
        gate_num = NUM_W'(gate_count);
        gate_den = CNT_W'(10);
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      afm_pkg::ST_IDLE: begin
        if (accept) begin
          if (gate_reading || per_divide) begin
            state_d = afm_pkg::ST_DIV_START;
          end else if (per_zero) begin
            state_d = afm_pkg::ST_SCALE;
          end else begin
            state_d = afm_pkg::ST_PUSH;
          end
        end
      end
      afm_pkg::ST_DIV_START: state_d = afm_pkg::ST_DIV_RUN;
      afm_pkg::ST_DIV_RUN: begin
        if (div_done) begin
          state_d = afm_pkg::ST_SCALE;
        end
      end
      afm_pkg::ST_SCALE: state_d = afm_pkg::ST_CMP;
      afm_pkg::ST_CMP:   state_d = afm_pkg::ST_PUSH;
      afm_pkg::ST_PUSH: begin
        if (out_free) begin
          state_d = afm_pkg::ST_IDLE;
        end
      end
      default: state_d = afm_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready_o = (state_q == afm_pkg::ST_IDLE);
    div_start  = (state_q == afm_pkg::ST_DIV_START);
    win_en     = (state_q == afm_pkg::ST_SCALE);
    out_free   = !m_tvalid_q || m_tready_i;
  end

  // Control state: sequencer, mode, readings
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= afm_pkg::ST_IDLE;
      mode_q  <= 1'b0;
      prev_q  <= '0;
      held_q  <= '0;
      unst_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        mode_q <= per_take ? 1'b0 : mode_after_gate;
      end
      if (state_q == afm_pkg::ST_CMP) begin
        prev_q <= r_q;
        unst_q <= !in_window;
        if (in_window) begin
          held_q <= r_q;
        end
      end
    end
  end

  // Operands and reading
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (gate_reading) begin
        num_q <= gate_num;
        den_q <= gate_den;
      end else begin
        num_q <= meter_enable_q ? afm_pkg::period_num(ref_clock_sel_q, period_cnt_sel_q)
                                : afm_pkg::NUM_FIXED;
        den_q <= period_count;
      end
      r_q <= '0;
    end else if ((state_q == afm_pkg::ST_DIV_RUN) && div_done) begin
      r_q <= quot_sat;
    end
  end

  // Rounded dividend: num * 2^FRAC_BITS + den / 2
  assign dividend = {num_q, {FRAC_BITS{1'b0}}} + DW'(den_q[CNT_W-1:1]);

  afm_div #(
    .DW    (DW),
    .DEN_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Saturate quotient to the reading width
  always_comb begin
    quot_ext = QX_W'(div_quot);
    quot_sat = (|quot_ext[QX_W-1:READ_W]) ? {READ_W{1'b1}} : quot_ext[READ_W-1:0];
  end

  afm_window u_window (
    .clk_i       (clk_i),
    .en_i        (win_en),
    .reading_i   (r_q),
    .prev_i      (prev_q),
    .in_window_o (in_window)
  );

  // Output register: load when the slot frees, drop valid after transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if ((state_q == afm_pkg::ST_PUSH) && out_free) begin
      m_tvalid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == afm_pkg::ST_PUSH) && out_free) begin
      m_tdata_q <= held_q;
      m_tuser_q <= {mode_q, unst_q};
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;
  assign m_tuser_o  = m_tuser_q;

endmodule

### rtl/afm_checker.sv
`include "auto_range_frequency_meter_macros.svh"

module afm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tvalid_i,
  input logic        s_tready_o,
  input logic        m_tvalid_o,
  input logic        m_tready_i,
  input logic [55:0] m_tdata_o,
  input logic [1:0]  m_tuser_o,
  input logic        pready
);

  // Configuration port never stalls
  `AFM_ASSERT_NOW(a_pready_high, 1'b1, pready)

  // An accepted item keeps the input closed in the following cycle
  `AFM_ASSERT_NEXT(a_one_item, s_tvalid_i && s_tready_o, !s_tready_o)

  // A stalled result holds
  `AFM_ASSERT_NEXT(a_out_hold, m_tvalid_o && !m_tready_i,
                   m_tvalid_o && $stable(m_tdata_o) && $stable(m_tuser_o))

endmodule

bind auto_range_frequency_meter afm_checker u_afm_checker (.*);
